// ===== rtl/mnr_pkg.sv =====
// Package for mixed_number_reduce: widths, payload structs, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mnr_pkg;
	localparam int DW = 16;
	localparam int TW = 2 * DW + 1;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic signed [DW-1:0] whole_part;
		logic signed [DW-1:0] numerator;
		logic signed [DW-1:0] denominator;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_whole;
		logic signed [31:0] out_numerator;
		logic signed [15:0] out_denominator;
		logic div_error;
	} out_word_t;

	typedef struct packed {
		logic signed [TW-1:0] t;
		logic signed [DW-1:0] d;
		logic zero_den;
		logic mixed;
	} job_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} q_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/mnr_front.sv =====
// Front end: takes a word, forms whole*den+num, pushes a job into a small queue.
// Depends on mnr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mnr_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire mnr_pkg::in_word_t in_word,
	input  wire logic mixed,
	output mnr_pkg::q_ctl_t qc,
	input  wire logic pop,
	output mnr_pkg::job_t job
);
	import mnr_pkg::*;

	logic v_s1;
	in_word_t w_s1;
	logic mix_s1;
	job_t mem_q [QDEPTH];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic push;
	job_t nj;
	logic signed [TW-1:0] prod;

	assign busy = v_s1 || (cnt_q == 2'(QDEPTH));
	assign prod = TW'(w_s1.whole_part) * TW'(w_s1.denominator);
	always_comb begin
		nj.t = prod + TW'(w_s1.numerator);
		nj.d = w_s1.denominator;
		nj.zero_den = (w_s1.denominator == '0);
		nj.mixed = mix_s1;
	end
	assign push = v_s1;
	assign qc.valid = (cnt_q != 2'd0);
	assign qc.ready = 1'b1;
	assign job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			w_s1 <= in_word;
			mix_s1 <= mixed;
		end
		if (push) mem_q[wp_q] <= nj;
	end
endmodule
`default_nettype wire

// ===== rtl/mnr_back.sv =====
// Back end: Euclid gcd and the divisions over a shared restoring divider.
// Depends on mnr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mnr_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mnr_pkg::q_ctl_t qc,
	input  wire mnr_pkg::job_t job,
	output logic pop,
	output logic done,
	output mnr_pkg::out_word_t res
);
	import mnr_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_GCD  = 7'b0000010,
		S_DIVT = 7'b0000100,
		S_DIVD = 7'b0001000,
		S_DIVQ = 7'b0010000,
		S_OUT  = 7'b0100000,
		S_WAIT = 7'b1000000
	} st_t;

	localparam int DB = TW + 1;
	localparam int CW = $clog2(DB + 1);

	st_t st_q;
	job_t j_q;
	logic signed [DB-1:0] a_q, b_q, rn_q, rd_q, g_q;
	logic [DB-1:0] num_q, den_q, rem_q, quo_q;
	logic nneg_q, dneg_q;
	logic [CW-1:0] bit_q;
	logic [DB:0] trial;
	logic [DB-1:0] rem_sh;
	logic signed [DB-1:0] qs, rs;
	logic div_busy;

	assign rem_sh = {rem_q[DB-2:0], num_q[DB-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, den_q};
	assign qs = (nneg_q ^ dneg_q) ? -$signed(quo_q) : $signed(quo_q);
	assign rs = nneg_q ? -$signed(rem_q) : $signed(rem_q);
	assign div_busy = (bit_q != '0);
	assign pop = (st_q == S_IDLE) && qc.valid && qc.ready;

	function automatic logic [DB-1:0] mag(input logic signed [DB-1:0] v);
		mag = v[DB-1] ? DB'(-v) : DB'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			bit_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (div_busy) begin
				bit_q <= bit_q - CW'(1);
			end else begin
				unique case (st_q)
					S_IDLE: if (pop) st_q <= job.zero_den ? S_OUT : S_GCD;
					S_GCD: begin
						if (b_q == '0) begin
							st_q <= S_DIVT;
							bit_q <= CW'(DB);
						end else begin
							bit_q <= CW'(DB);
							st_q <= S_WAIT;
						end
					end
					S_WAIT: st_q <= S_GCD;
					S_DIVT: begin
						st_q <= S_DIVD;
						bit_q <= CW'(DB);
					end
					S_DIVD: begin
						if (j_q.mixed) begin
							st_q <= S_DIVQ;
							bit_q <= CW'(DB);
						end else begin
							st_q <= S_OUT;
						end
					end
					S_DIVQ: st_q <= S_OUT;
					S_OUT: begin
						done <= 1'b1;
						st_q <= S_IDLE;
					end
					default: st_q <= S_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_busy) begin
			num_q <= {num_q[DB-2:0], 1'b0};
			if (!trial[DB]) begin
				rem_q <= trial[DB-1:0];
				quo_q <= {quo_q[DB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DB-2:0], 1'b0};
			end
		end else begin
			case (st_q)
				S_IDLE: if (pop) begin
					j_q <= job;
					a_q <= DB'(job.t);
					b_q <= DB'(job.d);
				end
				S_GCD: begin
					if (b_q == '0) begin
						g_q <= a_q;
						num_q <= mag(DB'(j_q.t));
						nneg_q <= j_q.t[TW-1];
						den_q <= mag(a_q);
						dneg_q <= a_q[DB-1];
					end else begin
						num_q <= mag(a_q);
						nneg_q <= a_q[DB-1];
						den_q <= mag(b_q);
						dneg_q <= b_q[DB-1];
					end
					rem_q <= '0;
					quo_q <= '0;
				end
				S_WAIT: begin
					a_q <= b_q;
					b_q <= rs;
				end
				S_DIVT: begin
					rn_q <= qs;
					num_q <= mag(DB'(j_q.d));
					nneg_q <= j_q.d[DW-1];
					den_q <= mag(g_q);
					dneg_q <= g_q[DB-1];
					rem_q <= '0;
					quo_q <= '0;
				end
				S_DIVD: begin
					rd_q <= qs;
					num_q <= mag(rn_q);
					nneg_q <= rn_q[DB-1];
					den_q <= mag(qs);
					dneg_q <= qs[DB-1];
					rem_q <= '0;
					quo_q <= '0;
				end
				S_DIVQ: begin
					a_q <= qs;
					b_q <= rs;
				end
				S_OUT: begin
					res.div_error <= j_q.zero_den;
					if (j_q.zero_den) begin
						res.out_whole <= '0;
						res.out_numerator <= '0;
						res.out_denominator <= '0;
					end else begin
						res.out_denominator <= 16'(rd_q);
						if (j_q.mixed) begin
							res.out_whole <= 32'(a_q);
							res.out_numerator <= 32'(b_q);
						end else begin
							res.out_whole <= '0;
							res.out_numerator <= 32'(rn_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qc.valid) else $error("pop on empty queue");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> st_q != S_IDLE) else $error("divider running while idle");
endmodule
`default_nettype wire

// ===== rtl/mixed_number_reduce.sv =====
// Top level of mixed_number_reduce: APB register, front end, back end.
// Depends on mnr_pkg, mnr_front, mnr_back.
//
// A word is accepted when start is high and busy is low. The front end forms
// whole*den+num in one stage and queues up to two jobs. The back end runs a
// Euclid gcd where each step is one pass of a 34-bit restoring divider
// plus the S_WAIT and S_GCD states, then divides numerator and denominator
// by the gcd, and in mixed form divides once more. The back end takes a
// new job only from idle, so it works on one word at a time over the
// shared serial divider; a zero denominator skips the divider.
// The result appears for one cycle with done high; the receiver cannot
// stall, so results are never held back. Reset clears the queue and the
// sequencer and sets mixed_output to 1. Register 0 at address 0 holds
// mixed_output in bit 0.
`timescale 1ns / 1ps
`default_nettype none
module mixed_number_reduce (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire mnr_pkg::in_word_t in_word,
	output logic done,
	output mnr_pkg::out_word_t out_word,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import mnr_pkg::*;

	localparam logic [1:0] REG_MIXED = 2'd0;

	logic mixed_q;
	q_ctl_t qc;
	job_t job;
	logic pop;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_MIXED) ? {31'd0, mixed_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mixed_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr == REG_MIXED) begin
			mixed_q <= pwdata[0];
		end
	end

	mnr_front u_front (.clk, .arst_n, .start, .busy, .in_word, .mixed(mixed_q),
		.qc, .pop, .job);
	mnr_back u_back (.clk, .arst_n, .qc, .job, .pop, .done, .res(out_word));
endmodule
`default_nettype wire

// ===== sim/tb_mixed_number_reduce.sv =====
// Self-checking testbench for mixed_number_reduce: drives mixed numbers through the
// start/busy handshake, writes the mode register over APB, and checks each word.
// Depends on mnr_pkg and the mixed_number_reduce RTL.
`timescale 1ns / 1ps
module tb_mixed_number_reduce;
	import mnr_pkg::*;

	localparam logic [1:0] ADDR_MIXED = 2'd0;
	localparam logic [1:0] ADDR_SPARE = 2'd1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_word_t in_word;
	logic done;
	out_word_t out_word;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	typedef struct {
		logic signed [15:0] w;
		logic signed [15:0] n;
		logic signed [15:0] d;
		bit has_fixed;
		out_word_t fixed;
	} stim_row_t;

	bit mode_mixed;
	out_word_t reduced_q[$];
	int errors;
	stim_row_t rows[$];

	mixed_number_reduce i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.done(done), .out_word(out_word), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAIL mixed_number_reduce");
		$finish;
	end

	function automatic longint euclid(longint a, longint b);
		longint r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic out_word_t reduce_mixed(logic signed [15:0] w, logic signed [15:0] n,
			logic signed [15:0] d, bit mixed);
		out_word_t o;
		longint t, g, rn, rd, q, r;
		o = '0;
		if (d == 0) begin
			o.div_error = 1'b1;
			return o;
		end
		t = longint'(w) * longint'(d) + longint'(n);
		g = euclid(t, longint'(d));
		rn = t / g;
		rd = longint'(d) / g;
		if (mixed) begin
			q = rn / rd;
			r = rn % rd;
		end else begin
			q = 0;
			r = rn;
		end
		o.out_whole = q[31:0];
		o.out_numerator = r[31:0];
		o.out_denominator = rd[15:0];
		return o;
	endfunction

	function automatic out_word_t mk(int q, int r, int rd, bit e);
		out_word_t o;
		o.out_whole = q;
		o.out_numerator = r;
		o.out_denominator = rd[15:0];
		o.div_error = e;
		return o;
	endfunction

	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && done) begin
			if (reduced_q.size() == 0) begin
				$display("%0t: unexpected word %p", $time, out_word);
				errors++;
			end else begin
				exp_w = reduced_q.pop_front();
				if (out_word.out_whole !== exp_w.out_whole) begin
					$display("%0t: out_whole exp %0d got %0d", $time, exp_w.out_whole,
						out_word.out_whole);
					errors++;
				end
				if (out_word.out_numerator !== exp_w.out_numerator) begin
					$display("%0t: out_numerator exp %0d got %0d", $time,
						exp_w.out_numerator, out_word.out_numerator);
					errors++;
				end
				if (out_word.out_denominator !== exp_w.out_denominator) begin
					$display("%0t: out_denominator exp %0d got %0d", $time,
						exp_w.out_denominator, out_word.out_denominator);
					errors++;
				end
				if (out_word.div_error !== exp_w.div_error) begin
					$display("%0t: div_error exp %0b got %0b", $time, exp_w.div_error,
						out_word.div_error);
					errors++;
				end
			end
		end
	end

	task automatic apb_write(logic [1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MIXED) mode_mixed = data[0];
	endtask

	task automatic drain();
		while (reduced_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Drives one word; idle gaps are inserted before start when gaps is set.
	task automatic send_word(logic signed [15:0] w, logic signed [15:0] n,
			logic signed [15:0] d, bit gaps, bit has_fixed, out_word_t fixed);
		in_word_t iw;
		while (gaps && $urandom_range(99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		iw.whole_part = w;
		iw.numerator = n;
		iw.denominator = d;
		start <= 1'b1;
		in_word <= iw;
		@(posedge clk);
		while (busy) @(posedge clk);
		reduced_q.push_back(has_fixed ? fixed : reduce_mixed(w, n, d, mode_mixed));
	endtask

	function automatic logic signed [15:0] pick16();
		case ($urandom_range(5))
			0: return 16'(signed'($urandom_range(0, 65535)));
			1: return 16'sd0;
			2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 16'(signed'($urandom_range(0, 40)) - 20);
		endcase
	endfunction

	task automatic random_phase(int count, bit gaps);
		logic signed [15:0] w, n, d;
		for (int i = 0; i < count; i++) begin
			w = pick16();
			n = pick16();
			d = pick16();
			if ($urandom_range(15) == 0) d = -16'sd32768;
			send_word(w, n, d, gaps, 1'b0, '0);
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		stim_row_t r;
		errors = 0;
		mode_mixed = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{16'sd1, 16'sd1, 16'sd0, 1'b1, mk(0, 0, 0, 1'b1)},
			'{16'sd0, 16'sd0, 16'sd5, 1'b1, mk(0, 0, 1, 1'b0)},
			'{16'sd2, 16'sd1, 16'sd2, 1'b1, mk(2, 1, 2, 1'b0)},
			'{16'sd0, 16'sd3, 16'sd6, 1'b0, '0},
			'{16'sd1, 16'sd5, 16'sd3, 1'b0, '0},
			'{-16'sd3, 16'sd1, 16'sd4, 1'b0, '0},
			'{16'sd2, -16'sd7, -16'sd9, 1'b0, '0},
			'{16'sd0, 16'sd1, -16'sd32768, 1'b0, '0},
			'{16'sd1, 16'sd0, -16'sd32768, 1'b0, '0},
			'{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0},
			'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
			'{16'sh7fff, -16'sd32768, 16'sh7fff, 1'b0, '0},
			'{-16'sd32768, 16'sh7fff, -16'sd1, 1'b0, '0},
			'{16'sd0, -16'sd1, 16'sd1, 1'b0, '0},
			'{16'sd5, 16'sd0, 16'sd0, 1'b1, mk(0, 0, 0, 1'b1)},
			'{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0},
			'{16'sh5555, 16'shaaaa, 16'sh1234, 1'b0, '0}
		};

		foreach (rows[i]) begin
			r = rows[i];
			send_word(r.w, r.n, r.d, 1'b0, r.has_fixed, r.fixed);
		end
		start <= 1'b0;
		@(posedge clk);
		drain();

		apb_write(ADDR_MIXED, 32'hffff_fffe);
		apb_write(ADDR_SPARE, 32'h0000_0001);
		foreach (rows[i]) begin
			r = rows[i];
			send_word(r.w, r.n, r.d, 1'b0, 1'b0, '0);
		end
		start <= 1'b0;
		@(posedge clk);
		random_phase(350, 1'b1);
		drain();

		apb_write(ADDR_MIXED, 32'h0000_0001);
		random_phase(400, 1'b0);
		drain();

		apb_write(ADDR_MIXED, 32'h0000_0000);
		random_phase(350, 1'b1);
		drain();

		apb_write(ADDR_MIXED, 32'hffff_ffff);
		random_phase(320, 1'b1);
		drain();

		if (errors == 0) begin
			$display("PASS mixed_number_reduce");
		end else begin
			$display("FAIL mixed_number_reduce");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/mnr_pkg.sv
rtl/mnr_front.sv
rtl/mnr_back.sv
rtl/mixed_number_reduce.sv
sim/tb_mixed_number_reduce.sv
